[rtl/bounded_squared_l2_distance_top_assert.svh]
// Assertion macros shared by the distance block.
// Each macro expects clk and rst_n in scope.
`ifndef BOUNDED_SQUARED_L2_DISTANCE_TOP_ASSERT_SVH
`define BOUNDED_SQUARED_L2_DISTANCE_TOP_ASSERT_SVH

// Same-cycle implication
`define BSQD_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BSQD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bsqd_pkg.sv]
`timescale 1ns / 1ps

package bsqd_pkg;

    // Port width of an element field and the bits of it actually used
    localparam int ELEM_W      = 16;
    localparam int ELEM_BITS   = 16;

    // Elements per bound check
    localparam int CHECK_BLOCK = 64;
    localparam int POS_W       = (CHECK_BLOCK > 1) ? $clog2(CHECK_BLOCK) : 1;
    localparam logic [POS_W-1:0] CHECK_LAST = POS_W'(CHECK_BLOCK - 1);

    // Difference, square and sum widths
    localparam int DIFF_W = ELEM_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = 48;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Squared difference handed from the front end to the accumulator
    typedef struct packed {
        logic [SQ_W-1:0] sq;
        logic            last;
    } bsqd_sq_t;

endpackage

[rtl/bsqd_front.sv]
`timescale 1ns / 1ps

module bsqd_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             elem_valid,
    output logic                             elem_stall,
    input  logic signed [bsqd_pkg::ELEM_W-1:0] elem_a,
    input  logic signed [bsqd_pkg::ELEM_W-1:0] elem_b,
    input  logic                             last_elem,
    output logic                             sq_valid,
    input  logic                             sq_ready,
    output bsqd_pkg::bsqd_sq_t               sq_item
);

    // Input stage
    logic                                in_valid_reg, in_valid_next;
    logic signed [bsqd_pkg::ELEM_BITS-1:0] a_reg;
    logic signed [bsqd_pkg::ELEM_BITS-1:0] b_reg;
    logic                                last_reg;

    // Square stage
    logic                sq_valid_reg, sq_valid_next;
    bsqd_pkg::bsqd_sq_t  sq_item_reg;

    logic                                in_load;
    logic                                sq_load;
    logic signed [bsqd_pkg::DIFF_W-1:0]  diff;
    logic signed [bsqd_pkg::SQ_W-1:0]    prod;

    // Handshake between stages
    assign sq_load    = in_valid_reg && (!sq_valid_reg || sq_ready);
    assign elem_stall = in_valid_reg && !(!sq_valid_reg || sq_ready);
    assign in_load    = elem_valid && !elem_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
            in_valid_next = 1'b1;
        else if (sq_load)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        sq_valid_next = sq_valid_reg;
        if (sq_load)
            sq_valid_next = 1'b1;
        else if (sq_ready)
            sq_valid_next = 1'b0;
    end

    // Exact difference and square
    assign diff = {a_reg[bsqd_pkg::ELEM_BITS-1], a_reg}
                - {b_reg[bsqd_pkg::ELEM_BITS-1], b_reg};
    assign prod = diff * diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            sq_valid_reg <= sq_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            a_reg    <= elem_a[bsqd_pkg::ELEM_BITS-1:0];
            b_reg    <= elem_b[bsqd_pkg::ELEM_BITS-1:0];
            last_reg <= last_elem;
        end
        if (sq_load)
        begin
            sq_item_reg.sq   <= prod;
            sq_item_reg.last <= last_reg;
        end
    end

    assign sq_valid = sq_valid_reg;
    assign sq_item  = sq_item_reg;

endmodule

[rtl/bsqd_accum.sv]
`timescale 1ns / 1ps

`include "bounded_squared_l2_distance_top_assert.svh"

module bsqd_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sq_valid,
    output logic                          sq_ready,
    input  bsqd_pkg::bsqd_sq_t            sq_item,
    input  logic [bsqd_pkg::SUM_W-1:0]    bound,
    output logic                          dist_valid,
    input  logic                          dist_stall,
    output logic [bsqd_pkg::SUM_W-1:0]    distance,
    output logic                          bound_exceeded
);

    // Per-vector state
    logic [bsqd_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [bsqd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       abandoned_reg, abandoned_next;

    // Result register
    logic                       dist_valid_reg, dist_valid_next;
    logic [bsqd_pkg::SUM_W-1:0] distance_reg;
    logic                       exceeded_reg;

    logic [bsqd_pkg::SUM_W:0]   sum_wide;
    logic [bsqd_pkg::SUM_W-1:0] sum_new;
    logic                       over;
    logic                       at_check;
    logic                       emit;
    logic                       out_free;
    logic                       acc_fire;

    // Saturating add and bound compare
    assign sum_wide = {1'b0, sum_reg}
                    + {{(bsqd_pkg::SUM_W + 1 - bsqd_pkg::SQ_W){1'b0}}, sq_item.sq};
    assign sum_new  = sum_wide[bsqd_pkg::SUM_W] ? bsqd_pkg::SUM_MAX
                                                : sum_wide[bsqd_pkg::SUM_W-1:0];
    assign over     = sum_new > bound;
    assign at_check = pos_reg == bsqd_pkg::CHECK_LAST;

    // A result goes out on the last element of a vector not abandoned or on a failed block check
    assign emit     = !abandoned_reg && (sq_item.last || (at_check && over));
    assign out_free = !dist_valid_reg || !dist_stall;
    assign sq_ready = !emit || out_free;
    assign acc_fire = sq_valid && sq_ready;

    // State update
    always_comb
    begin
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        abandoned_next = abandoned_reg;
        if (acc_fire)
        begin
            if (sq_item.last)
            begin
                sum_next       = '0;
                pos_next       = '0;
                abandoned_next = 1'b0;
            end
            else if (!abandoned_reg)
            begin
                sum_next = sum_new;
                pos_next = at_check ? '0 : pos_reg + 1'b1;
                if (at_check && over)
                    abandoned_next = 1'b1;
            end
        end
    end

    // Output valid
    always_comb
    begin
        dist_valid_next = dist_valid_reg;
        if (acc_fire && emit)
            dist_valid_next = 1'b1;
        else if (!dist_stall)
            dist_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            pos_reg        <= '0;
            abandoned_reg  <= 1'b0;
            dist_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            pos_reg        <= pos_next;
            abandoned_reg  <= abandoned_next;
            dist_valid_reg <= dist_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (acc_fire && emit)
        begin
            distance_reg <= sum_new;
            exceeded_reg <= over;
        end
    end

    assign dist_valid     = dist_valid_reg;
    assign distance       = distance_reg;
    assign bound_exceeded = exceeded_reg;

    // Checks
    `BSQD_ASSERT_NEXT(a_abandon_emits, acc_fire && !abandoned_reg && !sq_item.last && at_check && over, abandoned_reg && dist_valid_reg && exceeded_reg, "abandon without exceeded result")
    `BSQD_ASSERT_IMPL(a_abandon_pos, abandoned_reg, pos_reg == '0, "block position moved while abandoned")
    `BSQD_ASSERT_IMPL(a_abandon_end, $fell(abandoned_reg), $past(acc_fire && sq_item.last), "abandon cleared without last element")
    `BSQD_ASSERT_NEXT(a_sum_monotonic, acc_fire && !abandoned_reg && !sq_item.last, sum_reg >= $past(sum_reg), "running sum decreased inside a vector")

endmodule

[rtl/bounded_squared_l2_distance_top.sv]
// Bounded squared L2 distance with early abandon. Each transaction on the element channel
// carries one pair of signed 16-bit fixed-point elements; the block accumulates the squared
// difference into a 48-bit saturating sum and checks it against distance_bound after every
// 64 elements of a vector. A sum above the bound produces one result with bound_exceeded set
// and the rest of that vector, through the element marked last, is dropped; otherwise a result
// comes out at the last element. The block takes one element pair per clock, sustained, while
// elem_stall is low. An accepted element loads the input register, then the square register
// (one 17x17 multiply), and then the 48-bit add and compare load the result register. A
// result held by dist_stall holds up the stream only when the element behind it would produce
// another result; elements that produce none keep flowing. distance_bound resets to all ones
// and should be written only while no vector is in flight.
`timescale 1ns / 1ps

module bounded_squared_l2_distance_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsqd_pkg::SUM_W-1:0]         distance_bound,
    // Element stream
    input  logic                               elem_valid,
    output logic                               elem_stall,
    input  logic signed [bsqd_pkg::ELEM_W-1:0] elem_a,
    input  logic signed [bsqd_pkg::ELEM_W-1:0] elem_b,
    input  logic                               last_elem,
    // Distance results
    output logic                               dist_valid,
    input  logic                               dist_stall,
    output logic [bsqd_pkg::SUM_W-1:0]         distance,
    output logic                               bound_exceeded
);

    logic [bsqd_pkg::SUM_W-1:0] bound_reg;
    logic                       sq_valid;
    logic                       sq_ready;
    bsqd_pkg::bsqd_sq_t         sq_item;

    // Bound register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bound_reg <= bsqd_pkg::SUM_MAX;
        else if (cfg_valid && cfg_ready)
            bound_reg <= distance_bound;
    end

    // Difference and square
    bsqd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_stall (elem_stall),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .last_elem  (last_elem),
        .sq_valid   (sq_valid),
        .sq_ready   (sq_ready),
        .sq_item    (sq_item)
    );

    // Accumulate, check and emit
    bsqd_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .sq_valid       (sq_valid),
        .sq_ready       (sq_ready),
        .sq_item        (sq_item),
        .bound          (bound_reg),
        .dist_valid     (dist_valid),
        .dist_stall     (dist_stall),
        .distance       (distance),
        .bound_exceeded (bound_exceeded)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // Cycles of pipeline drain before a bound write or the final verdict
    localparam int DRAIN_CYCLES   = 8;
    // Cycles with no transaction on any channel before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 160;

    localparam logic [bsqd_pkg::SUM_W-1:0] FULL_SWING_SQ = 48'd4294836225;  // 65535^2

    typedef struct packed {
        logic [bsqd_pkg::SUM_W-1:0] dist_sum;
        logic                       exc;
    } dist_result_t;

    // One directed row: a pair repeated reps times, last on the final repeat if the row's last is set
    typedef struct packed {
        logic [bsqd_pkg::SUM_W-1:0]  bound;
        logic [bsqd_pkg::ELEM_W-1:0] a;
        logic [bsqd_pkg::ELEM_W-1:0] b;
        int                          reps;
        logic                        last;
        logic                        typed;
        logic [bsqd_pkg::SUM_W-1:0]  t_dist;
        logic                        t_exc;
    } pair_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [bsqd_pkg::SUM_W-1:0]         distance_bound;
    logic                               elem_valid;
    logic                               elem_stall;
    logic signed [bsqd_pkg::ELEM_W-1:0] elem_a;
    logic signed [bsqd_pkg::ELEM_W-1:0] elem_b;
    logic                               last_elem;
    logic                               dist_valid;
    logic                               dist_stall;
    logic [bsqd_pkg::SUM_W-1:0]         distance;
    logic                               bound_exceeded;

    // Predictor state
    logic [bsqd_pkg::SUM_W-1:0] bound_cfg;
    logic [bsqd_pkg::SUM_W-1:0] sum_acc;
    int                         blk_pos;
    bit                         dropping;

    dist_result_t pending_distances[$];
    dist_result_t want;
    int           errors;
    int           quiet_cycles;
    int           stall_left;
    bit           calm;

    pair_row_t directed_rows [20] = '{
        // single-element vectors and one four-element vector, reset bound
        '{bsqd_pkg::SUM_MAX, 16'h0000, 16'h0000, 1, 1'b1, 1'b1, 48'd0, 1'b0},
        '{bsqd_pkg::SUM_MAX, 16'h7fff, 16'h8000, 1, 1'b1, 1'b1, FULL_SWING_SQ, 1'b0},
        '{bsqd_pkg::SUM_MAX, 16'h8000, 16'h7fff, 1, 1'b1, 1'b1, FULL_SWING_SQ, 1'b0},
        '{bsqd_pkg::SUM_MAX, 16'h8000, 16'h8000, 1, 1'b1, 1'b1, 48'd0, 1'b0},
        '{bsqd_pkg::SUM_MAX, 16'h0005, 16'hfffd, 3, 1'b0, 1'b0, 48'd0, 1'b0},
        '{bsqd_pkg::SUM_MAX, 16'hffff, 16'h0002, 1, 1'b1, 1'b0, 48'd0, 1'b0},
        // zero bound: flag at last, exceeded on last element, abandon
        '{48'd0, 16'h0001, 16'h0000, 1, 1'b1, 1'b1, 48'd1, 1'b1},
        '{48'd0, 16'h0007, 16'h0007, 1, 1'b1, 1'b1, 48'd0, 1'b0},
        '{48'd0, 16'h0001, 16'h0000, 64, 1'b1, 1'b1, 48'd64, 1'b1},
        '{48'd0, 16'h0001, 16'h0000, 64, 1'b0, 1'b1, 48'd64, 1'b1},
        '{48'd0, 16'hff9c, 16'h0064, 5, 1'b0, 1'b0, 48'd0, 1'b0},
        '{48'd0, 16'h0003, 16'h0003, 1, 1'b1, 1'b0, 48'd0, 1'b0},
        '{48'd0, 16'h0002, 16'h0000, 1, 1'b1, 1'b1, 48'd4, 1'b1},
        // block check that passes, vector continues
        '{48'd4095, 16'h0001, 16'h0000, 63, 1'b0, 1'b0, 48'd0, 1'b0},
        '{48'd4095, 16'h0000, 16'h0000, 1, 1'b0, 1'b0, 48'd0, 1'b0},
        '{48'd4095, 16'h000a, 16'h0000, 1, 1'b1, 1'b0, 48'd0, 1'b0},
        // full-swing pairs against a full-swing bound: equal is not over, two pairs
        // exceed it at the last element, then an abandon at the first check
        '{FULL_SWING_SQ, 16'h7fff, 16'h8000, 1, 1'b1, 1'b1, FULL_SWING_SQ, 1'b0},
        '{FULL_SWING_SQ, 16'h7fff, 16'h8000, 2, 1'b1, 1'b0, 48'd0, 1'b0},
        '{FULL_SWING_SQ, 16'h8000, 16'h7fff, 64, 1'b0, 1'b0, 48'd0, 1'b0},
        '{FULL_SWING_SQ, 16'h0000, 16'h0000, 1, 1'b1, 1'b0, 48'd0, 1'b0}
    };

    bounded_squared_l2_distance_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .distance_bound (distance_bound),
        .elem_valid     (elem_valid),
        .elem_stall     (elem_stall),
        .elem_a         (elem_a),
        .elem_b         (elem_b),
        .last_elem      (last_elem),
        .dist_valid     (dist_valid),
        .dist_stall     (dist_stall),
        .distance       (distance),
        .bound_exceeded (bound_exceeded)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap length: mostly none, some short, a few long; none in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_vector();
        sum_acc  = '0;
        blk_pos  = 0;
        dropping = 1'b0;
    endfunction

    // Accumulate one element pair; returns 1 when the pair yields a distance
    function automatic bit accumulate_pair(input logic [bsqd_pkg::ELEM_W-1:0] a,
                                           input logic [bsqd_pkg::ELEM_W-1:0] b,
                                           input logic last,
                                           output logic [bsqd_pkg::SUM_W-1:0] sum_out,
                                           output logic exc);
        logic signed [bsqd_pkg::ELEM_BITS-1:0] va;
        logic signed [bsqd_pkg::ELEM_BITS-1:0] vb;
        longint                                diff;
        logic [63:0]                           wide;
        sum_out = '0;
        exc     = 1'b0;
        if (dropping)
        begin
            if (last)
                clear_vector();
            return 1'b0;
        end
        va   = a[bsqd_pkg::ELEM_BITS-1:0];
        vb   = b[bsqd_pkg::ELEM_BITS-1:0];
        diff = longint'(va) - longint'(vb);
        if (diff < 0)
            diff = -diff;
        wide = 64'(sum_acc) + 64'(diff * diff);
        sum_acc = (wide > 64'(bsqd_pkg::SUM_MAX)) ? bsqd_pkg::SUM_MAX
                                                  : wide[bsqd_pkg::SUM_W-1:0];
        blk_pos++;
        if (blk_pos >= bsqd_pkg::CHECK_BLOCK)
        begin
            blk_pos = 0;
            if (sum_acc > bound_cfg)
            begin
                sum_out = sum_acc;
                exc     = 1'b1;
                if (last)
                    clear_vector();
                else
                    dropping = 1'b1;
                return 1'b1;
            end
        end
        if (last)
        begin
            sum_out = sum_acc;
            exc     = (sum_acc > bound_cfg);
            clear_vector();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Send one element pair; a typed result replaces the predicted one
    task automatic push_pair(input logic [bsqd_pkg::ELEM_W-1:0] a,
                             input logic [bsqd_pkg::ELEM_W-1:0] b,
                             input logic last, input logic typed,
                             input logic [bsqd_pkg::SUM_W-1:0] t_dist, input logic t_exc);
        int                         gap;
        logic [bsqd_pkg::SUM_W-1:0] d;
        logic                       x;
        gap = pick_gap();
        if (gap > 0)
        begin
            elem_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        elem_a     <= a;
        elem_b     <= b;
        last_elem  <= last;
        elem_valid <= 1'b1;
        @(posedge clk);
        while (elem_stall)
            @(posedge clk);
        if (accumulate_pair(a, b, last, d, x))
        begin
            if (typed)
            begin
                d = t_dist;
                x = t_exc;
            end
            pending_distances.push_back({d, x});
        end
        @(negedge clk);
    endtask

    // Bound write, only once the block has gone quiet
    task automatic write_bound(input logic [bsqd_pkg::SUM_W-1:0] value);
        elem_valid <= 1'b0;
        while (pending_distances.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        distance_bound <= value;
        cfg_valid      <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bound_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [bsqd_pkg::SUM_W-1:0] pick_bound();
        int                         r;
        logic [bsqd_pkg::SUM_W-1:0] raw;
        r   = $urandom_range(0, 9);
        raw = bsqd_pkg::SUM_W'({$urandom, $urandom});
        if (r == 0)
            return '0;
        else if (r == 1)
            return bsqd_pkg::SUM_MAX;
        return raw >> $urandom_range(8, 40);
    endfunction

    // Element value by vector style: small, full range, or extremes
    function automatic logic [bsqd_pkg::ELEM_W-1:0] pick_elem(input int style);
        int r;
        r = $urandom_range(0, 9);
        if (style == 2 || r == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        else if (style == 0)
            return bsqd_pkg::ELEM_W'($urandom_range(0, 128) - 64);
        return bsqd_pkg::ELEM_W'($urandom);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(1, 8);
        else if (r < 55)
            return $urandom_range(9, 63);
        else if (r < 80)
            return bsqd_pkg::CHECK_BLOCK * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
        return $urandom_range(65, 300);
    endfunction

    // Receiver backpressure on the distance channel
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            dist_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            dist_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
    end

    // Compare each distance transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && dist_valid && !dist_stall)
        begin
            if (pending_distances.size() == 0)
            begin
                $display("%0t: unexpected result distance=%0d exceeded=%0b",
                         $time, distance, bound_exceeded);
                errors++;
            end
            else
            begin
                want = pending_distances.pop_front();
                if (distance !== want.dist_sum)
                begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want.dist_sum, distance);
                    errors++;
                end
                if (bound_exceeded !== want.exc)
                begin
                    $display("%0t: bound_exceeded expected %0b actual %0b",
                             $time, want.exc, bound_exceeded);
                    errors++;
                end
            end
        end
    end

    // Hang detection: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (elem_valid && !elem_stall) || (dist_valid && !dist_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int style;
        int len;
        int sent;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        distance_bound = '0;
        elem_valid     = 1'b0;
        elem_a         = '0;
        elem_b         = '0;
        last_elem      = 1'b0;
        dist_stall     = 1'b0;
        calm           = 1'b0;
        stall_left     = 0;
        errors         = 0;
        quiet_cycles   = 0;
        bound_cfg      = bsqd_pkg::SUM_MAX;
        clear_vector();

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].bound != bound_cfg)
                write_bound(directed_rows[i].bound);
            for (int n = 0; n < directed_rows[i].reps; n++)
                push_pair(directed_rows[i].a, directed_rows[i].b,
                          directed_rows[i].last && (n == directed_rows[i].reps - 1),
                          directed_rows[i].typed, directed_rows[i].t_dist,
                          directed_rows[i].t_exc);
        end

        // Random vectors, a new bound per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_bound(pick_bound());
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                calm  = ($urandom_range(0, 7) == 0);
                style = $urandom_range(0, 3);
                if (style == 3)
                    style = 1;
                len = pick_len();
                for (int n = 0; n < len; n++)
                    push_pair(pick_elem(style), pick_elem(style), n == len - 1,
                              1'b0, '0, 1'b0);
                sent += len;
            end
        end

        elem_valid <= 1'b0;
        calm = 1'b0;
        while (pending_distances.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0 && pending_distances.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
